FILE: design/i2crrs_pkg.sv
// ----------------------------------------------------------------------------
// I2C register read sequencer package
// Item types and shared codes for the register read sequencer.
// ----------------------------------------------------------------------------
package i2crrs_pkg;

	// Operation codes of an input item
	localparam logic OP_START = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// Transfer status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_FAILED = 2'd2;

	// Enable / transmit-interrupt control codes
	localparam logic [1:0] CTL_NONE = 2'd0;
	localparam logic [1:0] CTL_ON   = 2'd1;
	localparam logic [1:0] CTL_OFF  = 2'd2;

	// Sequencer phase codes
	localparam logic [2:0] PH_ADDR_WRITE = 3'd0;
	localparam logic [2:0] PH_SUB_ADDR   = 3'd1;
	localparam logic [2:0] PH_START_READ = 3'd2;
	localparam logic [2:0] PH_READ_BYTE  = 3'd4;
	localparam logic [2:0] PH_READ_LAST  = 3'd5;
	localparam logic [2:0] PH_END        = 3'd6;

	// Address byte bits
	localparam logic [7:0] AUTO_INC_BIT = 8'h80;
	localparam logic [7:0] READ_FLAG    = 8'h01;

	typedef struct packed {
		logic       op;
		logic [7:0] device_address;
		logic [6:0] register_address;
		logic [7:0] byte_count;
		logic       nack_seen;
		logic       tx_empty;
		logic       rx_full;
		logic [7:0] rx_data;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       send_start;
		logic       send_stop;
		logic       flush;
		logic       arm_nak;
		logic [1:0] enable_ctl;
		logic [1:0] txi_ctl;
		logic       store_valid;
		logic [7:0] store_data;
		logic [7:0] store_index;
		logic [1:0] status;
	} out_item_t;

endpackage

FILE: design/i2crrs_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one start request or controller event.
// ----------------------------------------------------------------------------
interface i2crrs_in_if import i2crrs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/i2crrs_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the controller writes of one step.
// ----------------------------------------------------------------------------
interface i2crrs_out_if import i2crrs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/i2crrs_step.sv
// ----------------------------------------------------------------------------
// I2C register read sequencer step
// Holds the transfer state and works out the controller writes of one item.
// ----------------------------------------------------------------------------
module i2crrs_step import i2crrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	output out_item_t result
);

	logic [2:0] phase_q, phase_d;
	logic [1:0] xfer_status_q, xfer_status_d;
	logic [7:0] saved_device_q, saved_device_d;
	logic [6:0] saved_register_q, saved_register_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] next_index_q, next_index_d;
	logic [7:0] remaining_dec;

	assign remaining_dec = remaining_q - 8'd1;

	// Next state and result of one item
	always_comb begin
		phase_d          = phase_q;
		xfer_status_d    = xfer_status_q;
		saved_device_d   = saved_device_q;
		saved_register_d = saved_register_q;
		remaining_d      = remaining_q;
		next_index_d     = next_index_q;
		result           = '0;

		if (item.op == OP_START) begin
			xfer_status_d     = ST_BUSY;
			saved_device_d    = item.device_address;
			saved_register_d  = item.register_address;
			remaining_d       = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
			next_index_d      = 8'd0;
			phase_d           = PH_ADDR_WRITE;
			result.enable_ctl = CTL_ON;
			result.txi_ctl    = CTL_ON;
		end else if (item.nack_seen) begin
			// NACK after the last byte ends the transfer; anywhere else it fails
			if (phase_q == PH_READ_LAST) begin
				result.store_valid = 1'b1;
				result.store_data  = item.rx_data;
				result.store_index = next_index_q;
				result.send_stop   = 1'b1;
				xfer_status_d      = ST_DONE;
			end else begin
				result.send_stop = 1'b1;
				result.flush     = 1'b1;
				result.txi_ctl   = CTL_OFF;
				xfer_status_d    = ST_FAILED;
			end
			result.enable_ctl = CTL_OFF;
			phase_d           = PH_END;
		end else if (item.tx_empty || item.rx_full) begin
			case (phase_q)
				PH_ADDR_WRITE: begin
					result.tx_valid   = 1'b1;
					result.tx_byte    = saved_device_q & ~READ_FLAG;
					result.send_start = 1'b1;
					phase_d           = PH_SUB_ADDR;
				end
				PH_SUB_ADDR: begin
					result.tx_valid = 1'b1;
					result.tx_byte  = (remaining_q > 8'd1) ?
						(AUTO_INC_BIT | {1'b0, saved_register_q}) : {1'b0, saved_register_q};
					phase_d         = PH_START_READ;
				end
				PH_START_READ: begin
					result.tx_valid   = 1'b1;
					result.tx_byte    = saved_device_q | READ_FLAG;
					result.send_start = 1'b1;
					result.txi_ctl    = CTL_OFF;
					if (remaining_q == 8'd1) begin
						result.arm_nak = 1'b1;
						phase_d        = PH_READ_LAST;
					end else begin
						phase_d = PH_READ_BYTE;
					end
				end
				PH_READ_BYTE: begin
					result.store_valid = 1'b1;
					result.store_data  = item.rx_data;
					result.store_index = next_index_q;
					next_index_d       = next_index_q + 8'd1;
					remaining_d        = remaining_dec;
					// arm NAK ahead of the final byte
					if (remaining_dec == 8'd1) begin
						result.arm_nak = 1'b1;
						phase_d        = PH_READ_LAST;
					end
				end
				default: begin
				end
			endcase
		end

		result.status = xfer_status_d;
	end

	// Transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_END;
			xfer_status_q    <= ST_DONE;
			saved_device_q   <= 8'd0;
			saved_register_q <= 7'd0;
			remaining_q      <= 8'd0;
			next_index_q     <= 8'd0;
		end else if (step_en) begin
			phase_q          <= phase_d;
			xfer_status_q    <= xfer_status_d;
			saved_device_q   <= saved_device_d;
			saved_register_q <= saved_register_d;
			remaining_q      <= remaining_d;
			next_index_q     <= next_index_d;
		end
	end

endmodule

FILE: design/i2c_register_read_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C register read sequencer
// Master-side sequencer driving an interrupt-based I2C register read.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one item per handshake: a start request (device address,
//          register address, byte count) or a controller event (NACK,
//          transmit empty, receive full, received byte).
//   out_ch gives exactly one result item per input item: the byte to write,
//          start/stop/flush/NAK commands, enable and transmit-interrupt
//          changes, a received byte with its store index, and the status.
//   The result passes through the input register, then the step logic
//   feeding the result register; a receiver stall can hold it in between.
//   Throughput is one item per cycle while the receiver takes results;
//   the transfer state is registered together with the result.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ch.ready drops only when both are occupied.
//   Reset clears both pipeline stages and puts the sequencer in the
//   end-of-cycle phase with status done.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer_top import i2crrs_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	i2crrs_in_if.sink   in_ch,
	i2crrs_out_if.source out_ch
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      advance;
	out_item_t step_result;

	// Stage 1 moves into the result register when that is free or being taken
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
	end

	i2crrs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.item   (item_s1),
		.result (step_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_result;
		end
	end

endmodule
